@@ sv/lspf_pkg.sv @@
// shared types and constants of the lidar scan point filter
package lspf_pkg;

  // point count limits and field widths
  localparam int unsigned MAX_POINTS = 4096;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned DIST_W     = 18;
  localparam int unsigned QUAL_W     = 8;
  localparam int unsigned INT_W      = 6;
  localparam int unsigned DEG_W      = 9;
  localparam int unsigned BOUNDS_W   = 18;
  localparam int unsigned LIMITS_W   = 36;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 36;

  // index * 360 fits here, quotient is below 2^DEG_W
  localparam int unsigned NUM_W      = IDX_W + DEG_W;
  localparam int unsigned DIV_STEPS  = DEG_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE_PARTED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ORDER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BOUNDS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR1_BOUNDS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR2_BOUNDS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR3_BOUNDS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR4_BOUNDS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMITS = 3'd7;

  // reset values of the configuration registers
  localparam logic [BOUNDS_W-1:0] WINDOW_RESET  = 18'd184320;
  localparam logic [BOUNDS_W-1:0] SECTOR1_RESET = 18'd25640;
  localparam logic [BOUNDS_W-1:0] SECTOR_RESET  = 18'd71810;
  localparam logic [LIMITS_W-1:0] LIMITS_RESET  = 36'd10485760000;

  typedef struct packed {
    logic [DIST_W-1:0] dist_q2;
    logic [QUAL_W-1:0] quality;
    logic [CNT_W-1:0]  scan_points;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  slot;
    logic [DIST_W-1:0] range_q2;
    logic              no_return;
    logic [INT_W-1:0]  intensity;
    logic              last_point;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ sv/lidar_scan_point_filter_unit.sv @@
// top level of the lidar scan point filter: angle divider, angular mask, range gate
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+------------------------------------
//  in       | input     | in_valid/in_ready  | in_data: dist_q2, quality, scan_points
//  out      | output    | out_valid/out_ready| out_data: slot, range_q2, no_return,
//           |           |                    |   intensity, last_point
//  cfg      | input     | cfg_wr_en          | cfg_index, cfg_data (8 registers)
//
// one point goes from transaction to result register through these steps: capture
// in idle, forming index*360, the restoring divider (one quotient bit per
// cycle through the single compare/subtract unit) and the mask and range tests
// in the final step. in_ready is high only while idle.
// a result waiting in the output register does not block the next transaction;
// only the final step waits when the output register is still full.
// rst is synchronous: state goes idle, point index clears, registers take defaults.
module lidar_scan_point_filter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lspf_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lspf_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [lspf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lspf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lspf_pkg::*;

  // configuration registers
  logic                mode_parted;
  logic                reverse_order;
  logic [BOUNDS_W-1:0] window_bounds;
  logic [BOUNDS_W-1:0] sector1_bounds;
  logic [BOUNDS_W-1:0] sector2_bounds;
  logic [BOUNDS_W-1:0] sector3_bounds;
  logic [BOUNDS_W-1:0] sector4_bounds;
  logic [LIMITS_W-1:0] distance_limits;

  // sequencer and scan position
  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] point_index;
  logic [IDX_W-1:0] point_index_next;

  // captured transaction
  logic [DIST_W-1:0] dist_r;
  logic [INT_W-1:0]  intensity_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  idx_r;

  // divider registers
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  divisor;
  logic [DEG_W-1:0]  quo;
  logic [STEP_W-1:0] step;

  // control decode
  logic accept_in;
  logic load_out;
  logic div_last;

  // combinational helpers
  logic [CNT_W-1:0]  count_in;
  logic [CNT_W-1:0]  count_clamped;
  logic              sub_ok;
  logic [NUM_W-1:0]  numer;
  logic              masked;
  logic              in_win;
  logic              in_any_sector;
  logic [DIST_W-1:0] lim_a;
  logic [DIST_W-1:0] lim_b;
  logic [DIST_W-1:0] lo;
  logic [DIST_W-1:0] hi;
  logic [DIST_W-1:0] eff;
  logic              gate_ok;
  logic              is_last;
  out_item_t         result;

  // sector: half-open when start <= end, wraps otherwise
  function automatic logic hit_sector(input logic [BOUNDS_W-1:0] b,
                                      input logic [DEG_W-1:0]    ang);
    logic [DEG_W-1:0] s;
    logic [DEG_W-1:0] e;
    s = b[DEG_W-1:0];
    e = b[BOUNDS_W-1:DEG_W];
    if (s <= e) begin
      return (ang >= s) && (ang < e);
    end
    return (ang >= s) || (ang <= e);
  endfunction

  // window: both ends included, wraps when end < start
  function automatic logic hit_window(input logic [BOUNDS_W-1:0] b,
                                      input logic [DEG_W-1:0]    ang);
    logic [DEG_W-1:0] s;
    logic [DEG_W-1:0] e;
    s = b[DEG_W-1:0];
    e = b[BOUNDS_W-1:DEG_W];
    if (e >= s) begin
      return (ang >= s) && (ang <= e);
    end
    return (ang >= s) || (ang <= e);
  endfunction

  // count clamp: zero counts as one, above the limit counts as the limit
  assign count_in = in_data.scan_points;
  always_comb begin
    if (count_in == '0) begin
      count_clamped = CNT_W'(1);
    end else if (count_in > CNT_W'(MAX_POINTS)) begin
      count_clamped = CNT_W'(MAX_POINTS);
    end else begin
      count_clamped = count_in;
    end
  end

  // index * 360 as shift-add: 360 = 256 + 64 + 32 + 8
  assign numer = (NUM_W'(idx_r) << 8) + (NUM_W'(idx_r) << 6)
               + (NUM_W'(idx_r) << 5) + (NUM_W'(idx_r) << 3);

  // shared compare/subtract of the divider
  assign sub_ok   = (rem >= divisor);
  assign div_last = (step == STEP_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL:  in_ready = 1'b0;
      ST_DIV:  in_ready = 1'b0;
      ST_DONE: load_out = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept_in = in_valid && in_ready;

  // mask decision on the finished quotient
  assign in_win        = hit_window(window_bounds, quo);
  assign in_any_sector = hit_sector(sector1_bounds, quo) || hit_sector(sector2_bounds, quo)
                      || hit_sector(sector3_bounds, quo) || hit_sector(sector4_bounds, quo);
  assign masked        = mode_parted ? in_any_sector : !in_win;

  // range gate with the limits put in order
  assign lim_a   = distance_limits[DIST_W-1:0];
  assign lim_b   = distance_limits[LIMITS_W-1:DIST_W];
  assign lo      = (lim_b < lim_a) ? lim_b : lim_a;
  assign hi      = (lim_b < lim_a) ? lim_a : lim_b;
  assign eff     = masked ? '0 : dist_r;
  assign gate_ok = (eff > lo) && (eff < hi);

  assign is_last = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));

  always_comb begin
    result.slot       = reverse_order ? IDX_W'(count_r - CNT_W'(1) - CNT_W'(idx_r)) : idx_r;
    result.range_q2   = gate_ok ? eff : '0;
    result.no_return  = !gate_ok;
    result.intensity  = intensity_r;
    result.last_point = is_last;
  end

  assign point_index_next = is_last ? '0 : IDX_W'(idx_r + IDX_W'(1));

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        point_index <= point_index_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_parted     <= 1'b0;
      reverse_order   <= 1'b0;
      window_bounds   <= WINDOW_RESET;
      sector1_bounds  <= SECTOR1_RESET;
      sector2_bounds  <= SECTOR_RESET;
      sector3_bounds  <= SECTOR_RESET;
      sector4_bounds  <= SECTOR_RESET;
      distance_limits <= LIMITS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE_PARTED:     mode_parted     <= cfg_data[0];
        REG_REVERSE_ORDER:   reverse_order   <= cfg_data[0];
        REG_WINDOW_BOUNDS:   window_bounds   <= cfg_data[BOUNDS_W-1:0];
        REG_SECTOR1_BOUNDS:  sector1_bounds  <= cfg_data[BOUNDS_W-1:0];
        REG_SECTOR2_BOUNDS:  sector2_bounds  <= cfg_data[BOUNDS_W-1:0];
        REG_SECTOR3_BOUNDS:  sector3_bounds  <= cfg_data[BOUNDS_W-1:0];
        REG_SECTOR4_BOUNDS:  sector4_bounds  <= cfg_data[BOUNDS_W-1:0];
        REG_DISTANCE_LIMITS: distance_limits <= cfg_data[LIMITS_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      dist_r      <= in_data.dist_q2;
      intensity_r <= in_data.quality[QUAL_W-1:QUAL_W-INT_W];
      count_r     <= count_clamped;
      // count shrank mid-scan: restart at the first point
      idx_r       <= (CNT_W'(point_index) >= count_clamped) ? '0 : point_index;
    end
    if (state == ST_MUL) begin
      rem     <= numer;
      divisor <= NUM_W'(count_r) << (DIV_STEPS - 1);
      quo     <= '0;
      step    <= STEP_W'(DIV_STEPS);
    end else if (state == ST_DIV) begin
      if (sub_ok) begin
        rem <= rem - divisor;
      end
      quo     <= {quo[DEG_W-2:0], sub_ok};
      divisor <= divisor >> 1;
      step    <= step - STEP_W'(1);
    end
    if (load_out) begin
      out_data <= result;
    end
  end

endmodule

@@ sv/lspf_checker.sv @@
// port-level checks of the lidar scan point filter and their binding
module lspf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input lspf_pkg::out_item_t           out_data
);
  import lspf_pkg::*;

  // the block is busy for the cycle after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an input transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  // a point with no return carries zero range
  a_no_return_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.no_return) |-> (out_data.range_q2 == '0))
    else $error("no_return with nonzero range");

  // an accepted point lies strictly above the lower limit, so it is never zero
  a_return_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.no_return) |-> (out_data.range_q2 != '0))
    else $error("accepted point with zero range");

endmodule

bind lidar_scan_point_filter_unit lspf_checker u_lspf_checker (.*);

@@ tb/testbench.sv @@
// testbench of the lidar scan point filter: directed and random scans against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lspf_pkg::*;

  // generous run limit in clock cycles
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // cycles to let pass once nothing is expected any more
  localparam int unsigned DRAIN_CYCLES  = 16;
  // longest idle stretch that either side draws per transaction
  localparam int unsigned GAP_MAX       = 13;
  // mismatch lines printed before going quiet
  localparam int unsigned REPORT_LIMIT  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lidar_scan_point_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the block's registers and point index
  bit                    mask_parted;
  bit                    slot_reversed;
  logic [BOUNDS_W-1:0]   window_reg;
  logic [BOUNDS_W-1:0]   sector_reg [4];
  logic [LIMITS_W-1:0]   limits_reg;
  int unsigned           point_pos;

  // returns predicted for accepted points, oldest first
  out_item_t             pending_returns [$];
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count = 0;

  // idle control shared by the tests and the two sides
  int unsigned           send_gap_max = GAP_MAX;
  int unsigned           take_gap_max = GAP_MAX;
  int unsigned           hold_off_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lidar_scan_point_filter_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // mask sector: end excluded when it does not wrap, both ends included when it wraps
  function automatic bit angle_in_sector(logic [BOUNDS_W-1:0] b, int unsigned ang);
    int unsigned s;
    int unsigned e;
    s = b[DEG_W-1:0];
    e = b[BOUNDS_W-1:DEG_W];
    if (s <= e) return (ang >= s) && (ang < e);
    return (ang >= s) || (ang <= e);
  endfunction

  // keep window: both ends included, wraps when end is below start
  function automatic bit angle_in_window(logic [BOUNDS_W-1:0] b, int unsigned ang);
    int unsigned s;
    int unsigned e;
    s = b[DEG_W-1:0];
    e = b[BOUNDS_W-1:DEG_W];
    if (e >= s) return (ang >= s) && (ang <= e);
    return (ang >= s) || (ang <= e);
  endfunction

  function automatic void reset_filter_state();
    mask_parted   = 1'b0;
    slot_reversed = 1'b0;
    window_reg    = WINDOW_RESET;
    sector_reg[0] = SECTOR1_RESET;
    for (int k = 1; k < 4; k++) sector_reg[k] = SECTOR_RESET;
    limits_reg    = LIMITS_RESET;
    point_pos     = 0;
  endfunction

  // works out the return of one point and advances the point index
  function automatic out_item_t filter_point(in_item_t pt);
    int unsigned count;
    int unsigned ang;
    int unsigned lo;
    int unsigned hi;
    int unsigned eff;
    int unsigned swap;
    bit          masked;
    bit          accept;
    bit          last;
    out_item_t   r;
    count = pt.scan_points;
    // out-of-range counts clamp to 1 .. MAX_POINTS
    if (count == 0) count = 1;
    if (count > MAX_POINTS) count = MAX_POINTS;
    // count shrank in the middle of a scan: restart the index
    if (point_pos >= count) point_pos = 0;
    ang = (point_pos * 360) / count;
    if (mask_parted) begin
      masked = 1'b0;
      for (int k = 0; k < 4; k++) masked |= angle_in_sector(sector_reg[k], ang);
    end else begin
      masked = !angle_in_window(window_reg, ang);
    end
    // the gate limits are put in order before use
    lo = limits_reg[DIST_W-1:0];
    hi = limits_reg[LIMITS_W-1:DIST_W];
    if (hi < lo) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    // a masked point counts as no echo and never passes the gate
    eff    = masked ? 0 : pt.dist_q2;
    accept = (eff > lo) && (eff < hi);
    last   = (point_pos == count - 1);
    r.slot       = IDX_W'(slot_reversed ? (count - 1 - point_pos) : point_pos);
    r.range_q2   = accept ? DIST_W'(eff) : '0;
    r.no_return  = !accept;
    r.intensity  = pt.quality[QUAL_W-1:2];
    r.last_point = last;
    point_pos    = last ? 0 : point_pos + 1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offers one point, waits for the transaction and records its prediction;
  // valid stays high on return, so back-to-back points never drop valid in between
  task automatic send_point(in_item_t pt);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk); while (!in_ready);
    pending_returns.push_back(filter_point(pt));
  endtask

  // one register write; the leading edge keeps two writes from sharing a step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MODE_PARTED:     mask_parted   = val[0];
      REG_REVERSE_ORDER:   slot_reversed = val[0];
      REG_WINDOW_BOUNDS:   window_reg    = val[BOUNDS_W-1:0];
      REG_SECTOR1_BOUNDS:  sector_reg[0] = val[BOUNDS_W-1:0];
      REG_SECTOR2_BOUNDS:  sector_reg[1] = val[BOUNDS_W-1:0];
      REG_SECTOR3_BOUNDS:  sector_reg[2] = val[BOUNDS_W-1:0];
      REG_SECTOR4_BOUNDS:  sector_reg[3] = val[BOUNDS_W-1:0];
      REG_DISTANCE_LIMITS: limits_reg    = val[LIMITS_W-1:0];
      default: ;
    endcase
  endtask

  // drop valid, wait for every predicted return, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_returns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------------

  function automatic void report_field(string field, longint unsigned want,
                                       longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endfunction

  initial begin
    int unsigned wait_n;
    out_item_t   want;
    out_item_t   got;
    @(negedge rst);
    forever begin
      // a requested hold-off wins over the usual random stall
      if (hold_off_cycles > 0) begin
        wait_n = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        wait_n = $urandom_range(0, take_gap_max);
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (pending_returns.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected transaction, expected none actual %h", $time, got);
      end else begin
        want = pending_returns.pop_front();
        if (got.slot !== want.slot) report_field("slot", want.slot, got.slot);
        if (got.range_q2 !== want.range_q2)
          report_field("range_q2", want.range_q2, got.range_q2);
        if (got.no_return !== want.no_return)
          report_field("no_return", want.no_return, got.no_return);
        if (got.intensity !== want.intensity)
          report_field("intensity", want.intensity, got.intensity);
        if (got.last_point !== want.last_point)
          report_field("last_point", want.last_point, got.last_point);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_point(logic [DIST_W-1:0] dist_val,
                                          logic [QUAL_W-1:0] qual,
                                          logic [CNT_W-1:0] count);
    in_item_t pt;
    pt.dist_q2     = dist_val;
    pt.quality     = qual;
    pt.scan_points = count;
    return pt;
  endfunction

  // packs a degree pair as the bounds registers hold it
  function automatic logic [CFG_DATA_W-1:0] deg_pair(int unsigned start_deg,
                                                     int unsigned end_deg);
    return CFG_DATA_W'({DEG_W'(end_deg), DEG_W'(start_deg)});
  endfunction

  // mostly sane degrees, now and then raw bits with values above 359
  function automatic logic [CFG_DATA_W-1:0] rand_bounds();
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'(BOUNDS_W'($urandom));
    return deg_pair($urandom_range(0, 359), $urandom_range(0, 359));
  endfunction

  // distances cluster around the gate edges so both sides of each get hit
  function automatic logic [DIST_W-1:0] rand_distance();
    logic [DIST_W-1:0] edge_val;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: begin
        edge_val = $urandom_range(0, 1) ? limits_reg[DIST_W-1:0]
                                        : limits_reg[LIMITS_W-1:DIST_W];
        return DIST_W'(edge_val + $urandom_range(0, 2) - 1);
      end
      default: return DIST_W'($urandom);
    endcase
  endfunction

  // flavor 0 writes all zeros, flavor 1 all ones, anything else random values
  task automatic load_config(int unsigned flavor);
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    if (flavor < 2) begin
      for (int k = 0; k < 8; k++)
        write_reg(CFG_IDX_W'(k), flavor == 0 ? '0 : '1);
    end else begin
      write_reg(REG_MODE_PARTED, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(REG_REVERSE_ORDER, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(REG_WINDOW_BOUNDS, rand_bounds());
      write_reg(REG_SECTOR1_BOUNDS, rand_bounds());
      write_reg(REG_SECTOR2_BOUNDS, rand_bounds());
      write_reg(REG_SECTOR3_BOUNDS, rand_bounds());
      write_reg(REG_SECTOR4_BOUNDS, rand_bounds());
      // random pair, so roughly half of them arrive swapped
      lo = DIST_W'($urandom);
      hi = DIST_W'($urandom);
      write_reg(REG_DISTANCE_LIMITS, {hi, lo});
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults: full window, gate 0..40000, distance and quality extremes
  task automatic test_default_gate();
    send_point(make_point(18'd0,      8'd0,   13'd6));
    send_point(make_point(18'd1,      8'd3,   13'd6));
    send_point(make_point(18'd39999,  8'd4,   13'd6));
    send_point(make_point(18'd40000,  8'd255, 13'd6));
    send_point(make_point(18'h3FFFF,  8'd128, 13'd6));
    send_point(make_point(18'd20000,  8'd252, 13'd6));
    settle();
  endtask

  // wrapping window 300..60, reversed slots, swapped distance limits
  task automatic test_window_wrap();
    write_reg(REG_WINDOW_BOUNDS, deg_pair(300, 60));
    write_reg(REG_REVERSE_ORDER, CFG_DATA_W'(1));
    write_reg(REG_DISTANCE_LIMITS, {18'd100, 18'd50000});
    send_point(make_point(18'd5000,  8'd17,  13'd6));
    send_point(make_point(18'd5000,  8'd64,  13'd6));
    send_point(make_point(18'd5000,  8'd99,  13'd6));
    send_point(make_point(18'd100,   8'd200, 13'd6));
    send_point(make_point(18'd50000, 8'd33,  13'd6));
    send_point(make_point(18'd49999, 8'd1,   13'd6));
    settle();
  endtask

  // parted mode: wrapping sector, empty sector, sector above 359, end excluded
  task automatic test_mask_sectors();
    write_reg(REG_MODE_PARTED, CFG_DATA_W'(1));
    write_reg(REG_REVERSE_ORDER, CFG_DATA_W'(0));
    write_reg(REG_DISTANCE_LIMITS, {18'h3FFFF, 18'd0});
    write_reg(REG_SECTOR1_BOUNDS, deg_pair(350, 20));
    write_reg(REG_SECTOR2_BOUNDS, deg_pair(90, 90));
    write_reg(REG_SECTOR3_BOUNDS, deg_pair(400, 511));
    write_reg(REG_SECTOR4_BOUNDS, deg_pair(135, 180));
    for (int k = 0; k < 8; k++)
      send_point(make_point(DIST_W'(1000 * (k + 1)), QUAL_W'(k * 37), 13'd8));
    settle();
  endtask

  // zero count, count above the maximum, and a count that shrinks mid-scan
  task automatic test_count_edges();
    send_point(make_point(18'd777, 8'd10, 13'd0));
    send_point(make_point(18'd778, 8'd11, 13'd0));
    send_point(make_point(18'd779, 8'd12, 13'd8191));
    send_point(make_point(18'd780, 8'd13, 13'd4096));
    send_point(make_point(18'd781, 8'd14, 13'd1));
    settle();
  endtask

  // receiver holds off long while the sender keeps offering back to back,
  // so the output register fills and in_ready drops
  task automatic test_output_backpressure();
    load_config(2);
    send_gap_max    = 0;
    hold_off_cycles = 250;
    for (int k = 0; k < 24; k++)
      send_point(make_point(rand_distance(), QUAL_W'($urandom), 13'd24));
    send_gap_max = GAP_MAX;
    settle();
  endtask

  // mostly whole scans of small counts; partial scans of any count make the
  // index restart later; a few points carry a fresh random count each
  task automatic test_random_scans(int unsigned points);
    int unsigned sent;
    int unsigned count;
    int unsigned n;
    int unsigned kind;
    sent = 0;
    while (sent < points) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        count = $urandom_range(1, 48);
        n     = count;
      end else if (kind < 9) begin
        count = $urandom_range(0, 8191);
        n     = $urandom_range(1, 24);
      end else begin
        count = 0;
        n     = $urandom_range(1, 12);
      end
      // the last group is cut short so the phase sends exactly its share
      if (n > points - sent) n = points - sent;
      for (int k = 0; k < n; k++)
        send_point(make_point(rand_distance(), QUAL_W'($urandom),
                              kind == 9 ? CNT_W'($urandom) : CNT_W'(count)));
      sent += n;
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_filter_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_gate();
    test_window_wrap();
    test_mask_sectors();
    test_count_edges();
    test_output_backpressure();

    // random phases: first two at the register extremes, every fourth with no idling
    for (int phase = 0; phase < 12; phase++) begin
      load_config(phase < 2 ? phase : 2);
      if (phase % 4 == 3) begin
        send_gap_max = 0;
        take_gap_max = 0;
      end else begin
        send_gap_max = GAP_MAX;
        take_gap_max = GAP_MAX;
      end
      test_random_scans(100);
    end

    if (mismatch_count == 0) begin
      $display("lidar_scan_point_filter_unit: match");
    end else begin
      $display("lidar_scan_point_filter_unit: mismatch");
    end
    $finish;
  end

endmodule
